// ===== design/mexp_pkg.sv =====
// shared types and constants for the modular exponentiation unit
// used by the interfaces, the controller, the datapath and the top level
package mexp_pkg;

	// width of every payload field on the ports
	localparam int unsigned DATA_W = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_CHECK,
		ST_MULV,
		ST_SQLD,
		ST_SQ,
		ST_DONE
	} mexp_state_t;

	// where a datapath step writes its reduced sum
	typedef enum logic [1:0] {
		DST_ACC,
		DST_PW,
		DST_VAL
	} mexp_dst_t;

	typedef struct packed {
		logic      load;
		logic      step;
		logic      red_mode;
		mexp_dst_t dst;
		logic      setup_val;
		logic      setup_pw;
		logic      exp_shift;
		logic      out_load;
	} mexp_cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic exp_zero;
		logic exp_lsb;
	} mexp_status_t;

endpackage

// ===== design/mexp_in_if.sv =====
// input channel: base, exponent and modulus with valid/ready
// depends on mexp_pkg
interface mexp_in_if;
	import mexp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] base;
	logic [DATA_W-1:0] exponent;
	logic [DATA_W-1:0] modulus;

	modport source (output valid, output base, output exponent, output modulus, input ready);
	modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

// ===== design/mexp_out_if.sv =====
// output channel: result and error flag with valid/ready
// depends on mexp_pkg
interface mexp_out_if;
	import mexp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result;
	logic              error;

	modport source (output valid, output result, output error, input ready);
	modport sink   (input valid, input result, input error, output ready);
endinterface

// ===== design/mexp_dp.sv =====
// datapath: operand registers and a bit-serial modular multiply/reduce unit
// depends on mexp_pkg
module mexp_dp #(
	parameter int unsigned WIDTH = 64
) (
	input  logic                           clk,
	input  logic [mexp_pkg::DATA_W-1:0]    in_base,
	input  logic [mexp_pkg::DATA_W-1:0]    in_exponent,
	input  logic [mexp_pkg::DATA_W-1:0]    in_modulus,
	input  mexp_pkg::mexp_cmd_t            cmd,
	output mexp_pkg::mexp_status_t         status,
	output logic [mexp_pkg::DATA_W-1:0]    result,
	output logic                           error
);
	import mexp_pkg::*;

	logic [WIDTH-1:0]   n_q;
	logic [WIDTH-1:0]   e_q;
	logic [WIDTH-1:0]   val_q;
	logic [WIDTH-1:0]   pw_q;
	logic [WIDTH-1:0]   acc_q;
	logic [WIDTH-1:0]   y_q;
	logic [DATA_W-1:0]  res_q;
	logic               err_q;

	logic [WIDTH-1:0]   addend;
	logic [WIDTH+1:0]   sum;
	logic [WIDTH+1:0]   n1;
	logic [WIDTH+1:0]   n2;
	logic [WIDTH-1:0]   acc_d;
	logic               y_msb;

	assign y_msb = y_q[WIDTH-1];

	// reduce mode shifts one bit of y in (horner), multiply mode adds pw
	always_comb begin
		if (cmd.red_mode) begin
			addend = WIDTH'(y_msb);
		end else begin
			addend = y_msb ? pw_q : '0;
		end
	end

	// 2*acc + addend stays below 3n, so at most 2n comes off
	assign sum = {1'b0, acc_q, 1'b0} + {2'b00, addend};
	assign n1  = {2'b00, n_q};
	assign n2  = {1'b0, n_q, 1'b0};

	always_comb begin
		if (sum >= n2) begin
			acc_d = WIDTH'(sum - n2);
		end else if (sum >= n1) begin
			acc_d = WIDTH'(sum - n1);
		end else begin
			acc_d = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= in_modulus[WIDTH-1:0];
			e_q   <= in_exponent[WIDTH-1:0];
			val_q <= WIDTH'(1);
			y_q   <= in_base[WIDTH-1:0];
			acc_q <= '0;
		end else begin
			if (cmd.setup_val) begin
				acc_q <= '0;
				y_q   <= val_q;
			end else if (cmd.setup_pw) begin
				acc_q <= '0;
				y_q   <= pw_q;
			end else if (cmd.step) begin
				y_q <= {y_q[WIDTH-2:0], 1'b0};
				case (cmd.dst)
					DST_ACC: acc_q <= acc_d;
					DST_PW:  pw_q  <= acc_d;
					DST_VAL: val_q <= acc_d;
					default: acc_q <= acc_d;
				endcase
			end
			if (cmd.exp_shift) begin
				e_q <= {1'b0, e_q[WIDTH-1:1]};
			end
		end
		if (cmd.out_load) begin
			res_q <= status.mod_zero ? '0 : DATA_W'(val_q);
			err_q <= status.mod_zero;
		end
	end

	assign status.mod_zero = (n_q == '0);
	assign status.exp_zero = (e_q == '0);
	assign status.exp_lsb  = e_q[0];

	assign result = res_q;
	assign error  = err_q;

endmodule

// ===== design/mexp_ctrl.sv =====
// controller: sequences reduce, multiply and square passes over the exponent
// depends on mexp_pkg
module mexp_ctrl #(
	parameter int unsigned WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    out_ready,
	output logic                    out_valid,
	input  mexp_pkg::mexp_status_t  status,
	output mexp_pkg::mexp_cmd_t     cmd
);
	import mexp_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH);

	mexp_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          last;

	assign last = (cnt_q == CW'(WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (out_valid_q && !out_ready) || cmd.out_load;
			if (cmd.step) begin
				cnt_q <= last ? '0 : cnt_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.dst  = DST_ACC;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RED;
				end
			end
			ST_RED: begin
				cmd.step     = 1'b1;
				cmd.red_mode = 1'b1;
				if (last) begin
					cmd.dst = DST_PW;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.mod_zero || status.exp_zero) begin
					state_d = ST_DONE;
				end else if (status.exp_lsb) begin
					cmd.setup_val = 1'b1;
					state_d       = ST_MULV;
				end else begin
					cmd.setup_pw = 1'b1;
					state_d      = ST_SQ;
				end
			end
			ST_MULV: begin
				cmd.step = 1'b1;
				if (last) begin
					cmd.dst = DST_VAL;
					state_d = ST_SQLD;
				end
			end
			ST_SQLD: begin
				cmd.setup_pw = 1'b1;
				state_d      = ST_SQ;
			end
			ST_SQ: begin
				cmd.step = 1'b1;
				if (last) begin
					cmd.dst       = DST_PW;
					cmd.exp_shift = 1'b1;
					state_d       = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/modular_exponentiation_unit.sv =====
// sequence to out.valid: base reduction, then for each exponent bit up to the top set bit
//   a multiply pass if the bit is set and a square pass, then a last check and the output
//   register load, which waits while a previous result is still held there
// throughput: one word at a time; the bit-serial multiply/reduce unit takes one bit a cycle
// a new word is taken while the previous result still waits in the output register
// reset (arst_n low, asynchronous) returns the controller to idle and drops out.valid
module modular_exponentiation_unit #(
	parameter int unsigned WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	mexp_in_if.sink     in,
	mexp_out_if.source  out
);
	import mexp_pkg::*;

	// command and status between the sequencer and the arithmetic
	mexp_cmd_t    cmd;
	mexp_status_t status;

	// controller: idle -> reduce base (WIDTH steps) -> per exponent bit:
	// optional multiply val*pw, then square pw, each WIDTH steps
	mexp_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_ready (out.ready),
		.out_valid (out.valid),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: shift-and-add modular multiply, one multiplier bit per cycle,
	// with a single add and two parallel compares to keep the sum below n
	mexp_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk         (clk),
		.in_base     (in.base),
		.in_exponent (in.exponent),
		.in_modulus  (in.modulus),
		.cmd         (cmd),
		.status      (status),
		.result      (out.result),
		.error       (out.error)
	);

	// an accepted word keeps the input closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> !in.ready)
		else $error("input ready while a word is in progress");

	// the arithmetic only steps while the input side is closed
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in.ready)
		else $error("datapath stepping while idle");

	// a zero modulus word always reports a zero result
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.error |-> out.result == '0)
		else $error("error word with nonzero result");

endmodule

// ===== verif/modular_exponentiation_unit_tb.sv =====
// self-checking testbench for the modular exponentiation unit
// depends on mexp_pkg, mexp_in_if, mexp_out_if and modular_exponentiation_unit
module modular_exponentiation_unit_tb;
	import mexp_pkg::*;

	localparam int unsigned WIDTH        = 64;
	localparam int unsigned IDLE_PCT     = 20;     // chance of a gap per cycle, each side
	localparam int unsigned RANDOM_WORDS = 100;
	localparam int unsigned CALM_FIRST   = 30;     // words in [CALM_FIRST, CALM_LAST) never idle
	localparam int unsigned CALM_LAST    = 50;
	localparam int unsigned HOLD_AT      = 60;     // result count that starts the long hold-off
	localparam int unsigned HOLD_CYCLES  = 20000;  // covers two worst-case exponentiations
	localparam int unsigned STALL_LIMIT  = 60000;  // cycles with no word moving on either side
	localparam int unsigned DRAIN_CYCLES = 300;

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] exponent;
		logic [DATA_W-1:0] modulus;
	} operands_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              error;
	} modexp_t;

	logic clk = 1'b0;
	logic arst_n;

	mexp_in_if  in_if();
	mexp_out_if out_if();

	modular_exponentiation_unit #(
		.WIDTH(WIDTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_if),
		.out   (out_if)
	);

	operands_t operand_q[$];   // words still to be offered
	modexp_t   expected_q[$];  // predicted results, oldest first
	int unsigned words_sent   = 0;
	int unsigned words_seen   = 0;
	int unsigned mismatches   = 0;
	int unsigned hold_left    = 0;
	bit          hold_done    = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// (a * b) mod n over the exact double-width product
	function automatic logic [DATA_W-1:0] mul_reduce(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] n);
		logic [2*DATA_W-1:0] prod;
		prod = {{DATA_W{1'b0}}, a % n} * {{DATA_W{1'b0}}, b % n};
		return DATA_W'(prod % {{DATA_W{1'b0}}, n});
	endfunction

	// right-to-left square and multiply; only the low WIDTH bits of each field count
	function automatic modexp_t predict_modexp(input operands_t op);
		logic [DATA_W-1:0] msk;
		logic [DATA_W-1:0] e;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] pw;
		logic [DATA_W-1:0] val;
		modexp_t           r;
		msk = ALL_ONES >> (DATA_W - WIDTH);
		pw  = op.base & msk;
		e   = op.exponent & msk;
		m   = op.modulus & msk;
		// zero modulus wins over everything, exponent zero included
		if (m == '0) begin
			r.result = '0;
			r.error  = 1'b1;
			return r;
		end
		// zero exponent leaves val at 1, unreduced even for modulus one
		val = 1;
		while (e != '0) begin
			if (e[0])
				val = mul_reduce(val, pw, m);
			pw = mul_reduce(pw, pw, m);
			e  = e >> 1;
		end
		r.result = val & msk;
		r.error  = 1'b0;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_word(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] e,
			input logic [DATA_W-1:0] m);
		operand_q.push_back('{base: b, exponent: e, modulus: m});
	endtask

	// driver: a word stays on the bus until taken, then the next one or a gap follows
	always @(posedge clk) begin : drive
		operands_t op;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				op = '{base: in_if.base, exponent: in_if.exponent, modulus: in_if.modulus};
				expected_q.push_back(predict_modexp(op));
				words_sent++;
			end
			if (!in_if.valid || in_if.ready) begin
				if (operand_q.size() != 0 &&
						((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					op             = operand_q.pop_front();
					in_if.valid    <= 1'b1;
					in_if.base     <= op.base;
					in_if.exponent <= op.exponent;
					in_if.modulus  <= op.modulus;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end else begin
			in_if.valid    <= 1'b0;
			in_if.base     <= '0;
			in_if.exponent <= '0;
			in_if.modulus  <= '0;
		end
	end

	// monitor: checks every taken result word against the oldest prediction
	always @(posedge clk) begin : collect
		modexp_t want;
		logic    rdy;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				words_seen++;
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: result=%h error=%b",
						out_if.result, out_if.error);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (out_if.result !== want.result) begin
						$error("result: expected %h, actual %h", want.result, out_if.result);
						mismatches++;
					end
					if (out_if.error !== want.error) begin
						$error("error: expected %b, actual %b", want.error, out_if.error);
						mismatches++;
					end
				end
			end
			// one long hold-off lets the unit fill its output register and stall its input
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (words_seen == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rdy       = 1'b0;
			end else begin
				rdy = (words_seen >= CALM_FIRST && words_seen < CALM_LAST) ||
					$urandom_range(99) >= IDLE_PCT;
			end
			out_if.ready <= rdy;
		end else begin
			out_if.ready <= 1'b0;
		end
	end

	// watchdog on cycles in which no word moves at all
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] e;
		logic [DATA_W-1:0] m;
		int unsigned       r;
		int unsigned       k;

		arst_n = 1'b0;

		// directed: zero modulus, zero exponent, base above modulus, extremes
		add_word('0, '0, '0);
		add_word(ALL_ONES, ALL_ONES, '0);
		add_word(rand64(), '0, 1);
		add_word(ALL_ONES, '0, ALL_ONES);
		add_word('0, '0, 5);
		add_word('0, 5, 7);
		add_word(5, 1, 1);
		add_word(ALL_ONES, 2, 13);
		add_word(ALL_ONES, 1, 2);
		add_word(ALL_ONES, ALL_ONES, ALL_ONES);
		add_word(ALL_ONES - 1, ALL_ONES, ALL_ONES);
		add_word(2, 64, ALL_ONES);
		add_word(3, 4, 64'hFFFF_FFFF_FFFF_FFC5);
		add_word(1, ALL_ONES, ALL_ONES - 1);
		add_word(TOP_BIT, TOP_BIT, TOP_BIT | 1);
		add_word(64'h1234_5678_9ABC_DEF1, 3, 64'h1234_5678_9ABC_DEF1);
		add_word(rand64(), rand64(), TOP_BIT);

		// random: mostly short exponents to bound run time, some full width
		repeat (RANDOM_WORDS) begin
			r = $urandom_range(99);
			if (r < 4)
				m = '0;
			else if (r < 12)
				m = $urandom_range(255, 1);
			else if (r < 20)
				m = rand64() | TOP_BIT;
			else
				m = rand64();

			r = $urandom_range(99);
			if (r < 5)
				b = '0;
			else if (r < 10)
				b = 1;
			else if (r < 15)
				b = ALL_ONES;
			else if (r < 25)
				b = m + $urandom_range(3);
			else
				b = rand64();

			if ($urandom_range(99) < 12) begin
				e = rand64();
			end else begin
				k = $urandom_range(12);
				e = rand64() & ((64'd1 << k) - 1);
			end
			add_word(b, e, m);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (operand_q.size() != 0 || in_if.valid || expected_q.size() != 0)
			@(posedge clk);
		// let any stray word show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== modular_exponentiation_unit.f =====
design/mexp_pkg.sv
design/mexp_in_if.sv
design/mexp_out_if.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation_unit.sv
verif/modular_exponentiation_unit_tb.sv
